@@ hdl/ssp_pkg.sv @@
// Shared types, constants and sine table for the six-stage phaser.
`default_nettype none
package ssp_pkg;

  localparam int Stages = 6;
  localparam int SineDepth = 1024;
  localparam int IdxW = $clog2(SineDepth);
  localparam int StgW = $clog2(Stages);

  localparam logic [15:0] FeedbackReset = 16'd0;
  localparam logic [15:0] WetReset = 16'd32768;
  localparam logic [15:0] LowReset = 16'd1311;
  localparam logic [15:0] HighReset = 16'd4755;

  localparam logic [2:0] RegFeedback = 3'd0;
  localparam logic [2:0] RegWet = 3'd1;
  localparam logic [2:0] RegLow = 3'd2;
  localparam logic [2:0] RegHigh = 3'd3;
  localparam logic [2:0] RegStep = 3'd4;
  localparam logic [2:0] RegStart = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWEEP, ST_DIV, ST_FEED, ST_STAGE_Y, ST_STAGE_Z, ST_MIX, ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] feedback_gain;
    logic [15:0] wet_depth;
    logic [15:0] sweep_low;
    logic [15:0] sweep_high;
    logic [31:0] lfo_step;
    logic [31:0] lfo_start_phase;
  } cfg_t;

  localparam longint C1 = 64'sd1686629713;
  localparam longint C3 = -64'sd693598669;
  localparam longint C5 = 64'sd85569306;
  localparam longint C7 = -64'sd5026996;
  localparam longint OneQ30 = 64'sd1073741824;

  function automatic longint rshr(input longint p, input int s);
    longint r;
    r = (p + (64'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

  // Elaboration-time sine entry, Q0.16 of (sin+1)/2.
  function automatic logic [15:0] sine_entry(input int k);
    longint ph, u, u2, t, s, v;
    logic [1:0] quad;
    ph = (longint'(k) <<< 32) / SineDepth;
    quad = ph[31:30];
    u = ph & 64'h3FFF_FFFF;
    if (quad[0]) u = OneQ30 - u;
    u2 = rshr(u * u, 30);
    t = C7;
    t = C5 + rshr(t * u2, 30);
    t = C3 + rshr(t * u2, 30);
    t = C1 + rshr(t * u2, 30);
    s = rshr(t * u, 30);
    if (s > OneQ30) s = OneQ30;
    if (s < 0) s = 0;
    v = quad[1] ? OneQ30 - s : OneQ30 + s;
    v = (v + 64'sd16384) >>> 15;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ssp_stream_if.sv @@
// Valid/ready stream interfaces for samples in and out.
`default_nettype none
interface ssp_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample_in;
  logic restart;
  modport source(output valid, sample_in, restart, input ready);
  modport sink(input valid, sample_in, restart, output ready);
endinterface

interface ssp_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample_out;
  logic clipped;
  modport source(output valid, sample_out, clipped, input ready);
  modport sink(input valid, sample_out, clipped, output ready);
endinterface
`default_nettype wire

@@ hdl/six_stage_phaser_top.sv @@
// Top level of the six-stage phaser.
// Each sample passes through these states in order: accept it and read the
// sine table, form the sweep point, the coefficient divide state (45
// bit-serial divider steps; the feedback product is formed meanwhile), form
// the chain input, two states per all-pass stage on the shared multiplier,
// then the mix and the output. The input is not ready until the result
// transaction completes. Restart clears the stage memories and loads the
// start phase before the sample is processed.
`default_nettype none
module six_stage_phaser_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  ssp_in_if.sink  samples_in,
  ssp_out_if.source samples_out
);
  import ssp_pkg::*;
  cfg_t cfg;

  ssp_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  ssp_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(samples_in), .out_ch(samples_out)
  );
endmodule
`default_nettype wire

@@ hdl/ssp_regs.sv @@
// APB configuration register file.
`default_nettype none
module ssp_regs (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output ssp_pkg::cfg_t cfg
);
  import ssp_pkg::*;
  logic [2:0] idx;
  logic wr;
  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feedback_gain <= FeedbackReset;
      cfg.wet_depth <= WetReset;
      cfg.sweep_low <= LowReset;
      cfg.sweep_high <= HighReset;
      cfg.lfo_step <= '0;
      cfg.lfo_start_phase <= '0;
    end else if (wr) begin
      unique case (idx)
        RegFeedback: cfg.feedback_gain <= pwdata[15:0];
        RegWet:      cfg.wet_depth <= pwdata[15:0];
        RegLow:      cfg.sweep_low <= pwdata[15:0];
        RegHigh:     cfg.sweep_high <= pwdata[15:0];
        RegStep:     cfg.lfo_step <= pwdata;
        RegStart:    cfg.lfo_start_phase <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegFeedback: prdata = {16'd0, cfg.feedback_gain};
      RegWet:      prdata = {16'd0, cfg.wet_depth};
      RegLow:      prdata = {16'd0, cfg.sweep_low};
      RegHigh:     prdata = {16'd0, cfg.sweep_high};
      RegStep:     prdata = cfg.lfo_step;
      RegStart:    prdata = cfg.lfo_start_phase;
      default:     prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/ssp_divider.sv @@
// Restoring divider for the all-pass coefficient, one quotient bit per cycle.
`default_nettype none
module ssp_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [15:0] d,
  output logic busy,
  output logic [29:0] quotient
);
  // numerator (65536-d)<<28 < 2^45, quotient <= 2^28
  logic [16:0] den;
  logic [17:0] rem;
  logic [44:0] num;
  logic [5:0] cnt;
  logic [17:0] trial;
  logic [18:0] diff;

  assign trial = {rem[16:0], num[44]};
  assign diff = {1'b0, trial} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd45;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= 17'd65536 + {1'b0, d};
      num <= {(17'd65536 - {1'b0, d}), 28'd0};
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[43:0], 1'b0};
      if (!diff[18]) begin
        rem <= diff[17:0];
        quotient <= {quotient[28:0], 1'b1};
      end else begin
        rem <= trial;
        quotient <= {quotient[28:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/ssp_core.sv @@
// Sequencer with one shared multiply-round unit running the all-pass chain.
`default_nettype none
module ssp_core (
  input  wire logic clk,
  input  wire logic rst,
  input  ssp_pkg::cfg_t cfg,
  ssp_in_if.sink  in_ch,
  ssp_out_if.source out_ch
);
  import ssp_pkg::*;

  logic [15:0] sine_rom [SineDepth];
  for (genvar k = 0; k < SineDepth; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  state_t state, state_next;
  logic signed [31:0] zmem [Stages];
  logic signed [31:0] last_out;
  logic [31:0] phase;
  logic signed [15:0] sx;
  logic [15:0] w;
  logic [15:0] dval;
  logic signed [31:0] coef;
  logic signed [31:0] x, y;
  logic [StgW-1:0] stg;
  logic div_start, div_busy;
  logic [29:0] quot;

  // shared multiplier: 33x33 signed product of sign-extended 32-bit operands, combinational
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  assign prod = ma * mb;

  ssp_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .d(dval), .busy(div_busy), .quotient(quot)
  );

  logic [IdxW-1:0] tidx;
  logic [31:0] ph_now;
  assign ph_now = in_ch.restart ? cfg.lfo_start_phase : phase;
  assign tidx = ph_now[31:32-IdxW];

  logic [33:0] dsum;
  assign dsum = {18'd0, cfg.sweep_low} * (17'd65536 - {1'b0, w})
              + {18'd0, cfg.sweep_high} * {1'b0, w};

  function automatic logic signed [63:0] rnd(input logic signed [65:0] p, input int s);
    logic signed [65:0] r;
    r = (p + (66'sd1 <<< (s - 1))) >>> s;
    return r[63:0];
  endfunction

  logic signed [63:0] tmp;
  logic signed [16:0] mix;

  assign in_ch.ready = (state == ST_IDLE);
  assign div_start = (state == ST_SWEEP);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_ch.valid) state_next = ST_SWEEP;
      ST_SWEEP:   state_next = ST_DIV;
      ST_DIV:     if (!div_busy) state_next = ST_FEED;
      ST_FEED:    state_next = ST_STAGE_Y;
      ST_STAGE_Y: state_next = ST_STAGE_Z;
      ST_STAGE_Z: state_next = (stg == '0) ? ST_MIX : ST_STAGE_Y;
      ST_MIX:     state_next = ST_OUT;
      ST_OUT:     if (out_ch.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_DIV:     begin ma = {{17{cfg.feedback_gain[15]}}, cfg.feedback_gain};
                        mb = {last_out[31], last_out}; end
      ST_STAGE_Y: begin ma = {coef[31], coef}; mb = -{x[31], x}; end
      ST_STAGE_Z: begin ma = {coef[31], coef}; mb = {y[31], y}; end
      ST_MIX:     begin ma = {1'b0, 16'd0, cfg.wet_depth}; mb = {x[31], x}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      last_out <= '0;
      for (int i = 0; i < Stages; i++) zmem[i] <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          sx <= in_ch.sample_in;
          w <= sine_rom[tidx];
          phase <= ph_now + cfg.lfo_step;
          if (in_ch.restart) begin
            last_out <= '0;
            for (int i = 0; i < Stages; i++) zmem[i] <= '0;
          end
        end
        ST_SWEEP: ;
        ST_DIV: tmp <= rnd(prod, 15);
        ST_FEED: begin
          x <= sat32(64'(sx) * 64'sd8192 + tmp);
          coef <= 32'(quot);
          stg <= StgW'(Stages - 1);
        end
        ST_STAGE_Y: y <= sat32(64'(zmem[stg]) + rnd(prod, 28));
        ST_STAGE_Z: begin
          zmem[stg] <= sat32(rnd(prod, 28) + 64'(x));
          x <= y;
          stg <= stg - StgW'(1);
        end
        ST_MIX: begin
          last_out <= x;
          tmp <= 64'(sx) + rnd(prod, 28);
        end
        ST_OUT: ;
        default: ;
      endcase
      if (state == ST_MIX) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  assign mix = (tmp > 64'sd32767) ? 17'sd32767 :
               (tmp < -64'sd32768) ? -17'sd32768 : tmp[16:0];
  assign out_ch.sample_out = mix[15:0];
  assign out_ch.clipped = (tmp > 64'sd32767) || (tmp < -64'sd32768);

  // sweep point from the sine value latched at accept, ready for the divider start
  assign dval = dsum[31:16];

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV) else $error("divider busy outside divide");
  a_valid_from_mix: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_MIX) else $error("stray result");
endmodule
`default_nettype wire
